>>> rtl/bounded_unique_set_store_unit_macros.svh
// assertion macros for the bounded unique set store unit
// used by the port checker; needs no other file
`ifndef BOUNDED_UNIQUE_SET_STORE_UNIT_MACROS_SVH
`define BOUNDED_UNIQUE_SET_STORE_UNIT_MACROS_SVH

// clocked property, muted while reset is high
`define BUSS_ASSERT_RST(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, checked during reset as well
`define BUSS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/buss_pkg.sv
// shared types and constants of the bounded unique set store unit
// no dependencies; imported by every module of the block
package buss_pkg;

   localparam int DATA_W      = 32;
   localparam int IDX_W       = 5;
   localparam int CAP_W       = 5;
   localparam int CMD_W       = 2;
   localparam int ST_W        = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   localparam logic [CAP_W-1:0]  CAP_RESET = 5'd5;
   localparam logic [DATA_W-1:0] BAD_VALUE = 32'hFFFF_FFFF;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_GET    = 2'd3;

   // status codes
   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
   localparam logic [ST_W-1:0] ST_ABSENT    = 2'd2;
   localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd3;

   // per-cell update control
   typedef struct packed {
      logic load;   // take the incoming value (append here)
      logic shift;  // take the upper neighbor's value (compaction)
   } cell_ctrl_type;

endpackage

>>> rtl/buss_cell.sv
// one storage cell of the set: holds an entry, compares it, shifts down on remove
// depends on buss_pkg
module buss_cell (
   input  logic                                   clock,
   input  buss_pkg::cell_ctrl_type                ctrl,
   input  logic                                   valid,
   input  logic signed [buss_pkg::DATA_W-1:0]     item_value,
   input  logic signed [buss_pkg::DATA_W-1:0]     upper_value,
   output logic signed [buss_pkg::DATA_W-1:0]     value_out,
   output logic                                   match
);
   import buss_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   // next entry: append wins, then compaction
   always_comb begin
      priority if (ctrl.load) begin
         value_in = item_value;
      end else if (ctrl.shift) begin
         value_in = upper_value;
      end else begin
         value_in = value_ff;
      end
   end

   // entry register, payload only
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // compare only while the entry is in use
   assign match     = valid && (value_ff == item_value);
   assign value_out = value_ff;

endmodule

>>> rtl/bounded_unique_set_store_unit.sv
// top level of the bounded unique set store: a row of buss_cell cells plus count
// and response register; depends on buss_pkg and buss_cell
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tuser cmd, tdata item_value, slot_index
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata present, element_out, count, status
//  csr     | in  | csr_wr_en              | csr_wr_data capacity_limit
//
// all cells compare at once and a remove shifts the later cells down by one in
// the same cycle; the result sits in a register and shows the cycle after the
// transfer. the cell compare, the hit prefix over DEPTH cells and the count
// update set the clock path. reset clears the count and loads capacity 5;
// entries are left as they are. req_tready drops only while a result is held
// and rsp_tready is low.
module bounded_unique_set_store_unit #(
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [buss_pkg::REQ_TDATA_W-1:0]     req_tdata,  // item_value[31:0], slot_index[36:32], zero pad
   input  logic [buss_pkg::CMD_W-1:0]           req_tuser,  // cmd[1:0]
   // response
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [buss_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // present[0], element_out[32:1],
                                                            // entry_count[37:33], status[39:38]
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [buss_pkg::CAP_W-1:0]           csr_wr_data
);
   import buss_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LG = $clog2(DEPTH);
   localparam int WW = CW + IDX_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [CW-1:0]            count_ff, count_in;
   logic [CAP_W-1:0]         capacity_ff;
   logic                     rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic signed [DATA_W-1:0] item_value;
   logic [IDX_W-1:0]         slot_index;
   logic [IW-1:0]            read_sel;

   logic signed [DATA_W-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]         cell_valid;
   logic [DEPTH-1:0]         cell_hit;
   logic [DEPTH-1:0]         slot_free;
   logic [DEPTH-1:0]         load_vec, shift_vec;
   logic [DEPTH-1:0]         hit_prefix [LG+1];
   cell_ctrl_type            cell_ctrl [DEPTH];

   logic                     hit, full, in_range;
   logic                     present;
   logic signed [DATA_W-1:0] element;
   logic [ST_W-1:0]          status;

   // request fields
   assign accept     = req_tvalid && req_tready;
   assign item_value = req_tdata[DATA_W-1:0];
   assign slot_index = req_tdata[DATA_W+IDX_W-1:DATA_W];
   assign read_sel   = IW'(slot_index);
   assign req_tready = !rsp_valid_ff || rsp_tready;

   // per-cell occupancy and append slot
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_valid[i] = CW'(i) < count_ff;
         slot_free[i]  = CW'(i) == count_ff;
      end
   end

   // cell row; the top cell feeds itself
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [DATA_W-1:0] upper;
      if (g == DEPTH - 1) begin : g_top
         assign upper = cell_value[g];
      end else begin : g_mid
         assign upper = cell_value[g+1];
      end
      assign cell_ctrl[g].load  = load_vec[g];
      assign cell_ctrl[g].shift = shift_vec[g];
      buss_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[g]),
         .valid       (cell_valid[g]),
         .item_value  (item_value),
         .upper_value (upper),
         .value_out   (cell_value[g]),
         .match       (cell_hit[g])
      );
   end

   // cells at or above the hit position, log-depth prefix or
   always_comb begin
      hit_prefix[0] = cell_hit;
      for (int l = 0; l < LG; l++) begin
         hit_prefix[l+1] = hit_prefix[l] | (hit_prefix[l] << (1 << l));
      end
   end

   assign hit      = |cell_hit;
   assign full     = (WW'(count_ff) >= WW'(capacity_ff)) || (count_ff == DEPTH_C);
   assign in_range = WW'(slot_index) < WW'(count_ff);

   // command decode
   always_comb begin
      count_in  = count_ff;
      present   = 1'b0;
      element   = '0;
      status    = ST_OK;
      load_vec  = '0;
      shift_vec = '0;
      unique case (req_tuser)
         CMD_ADD: begin
            present = hit;
            if (full) begin
               status = ST_FULL;
            end else if (!hit) begin
               load_vec = accept ? slot_free : '0;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_REMOVE: begin
            present = hit;
            if (hit) begin
               shift_vec = accept ? hit_prefix[LG] : '0;
               count_in  = count_ff - 1'b1;
            end else begin
               status = ST_ABSENT;
            end
         end
         CMD_FIND: begin
            present = hit;
         end
         CMD_GET: begin
            if (in_range) begin
               element = cell_value[read_sel];
            end else begin
               element = BAD_VALUE;
               status  = ST_BAD_INDEX;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
      rsp_data_in = {status, 5'(count_in), element, present};
   end

   // count and capacity
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         capacity_ff <= CAP_RESET;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/buss_checker.sv
// port-level checker for the bounded unique set store unit, bound to the top level
// depends on buss_pkg and the assertion macro header
`include "bounded_unique_set_store_unit_macros.svh"

module buss_checker #(
   parameter int DEPTH = 16
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [buss_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import buss_pkg::*;

   logic             req_xfer;
   logic [ST_W-1:0]  rsp_status;
   logic [4:0]       rsp_count;
   logic [DATA_W-1:0] rsp_element;

   assign req_xfer    = req_tvalid && req_tready;
   assign rsp_status  = rsp_tdata[39:38];
   assign rsp_count   = rsp_tdata[37:33];
   assign rsp_element = rsp_tdata[32:1];

   // a stalled result holds
   `BUSS_ASSERT_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // every request transfer yields a result on the next cycle
   `BUSS_ASSERT_RST(a_rsp_follows, clock, reset, req_xfer |=> rsp_tvalid, "no result after request transfer")

   // input stalls only behind a held result
   `BUSS_ASSERT_RST(a_ready_stall, clock, reset, !req_tready |-> rsp_tvalid && !rsp_tready, "request stalled without backpressure")

   // bad index reads back all ones
   `BUSS_ASSERT_RST(a_bad_index, clock, reset, rsp_tvalid && rsp_status == ST_BAD_INDEX |-> rsp_element == BAD_VALUE, "bad index result not all ones")

   // count never passes the store depth
   `BUSS_ASSERT_ALWAYS(a_count_bound, clock, rsp_tvalid |-> int'(rsp_count) <= DEPTH, "entry count above depth")

endmodule

bind bounded_unique_set_store_unit buss_checker #(.DEPTH(DEPTH)) u_buss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/sv/bounded_unique_set_store_unit_tb.sv
// testbench for bounded_unique_set_store_unit: drives commands and capacity writes,
// predicts every response with its own set model and checks it in order
// depends on buss_pkg and the rtl of the block
`timescale 1ns / 1ps

module bounded_unique_set_store_unit_tb;
   import buss_pkg::*;

   localparam int STORE_DEPTH = 16;
   localparam int POOL_SIZE   = 20;

   // response layout, lowest bit first: present, element, count, status
   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic [CAP_W-1:0]  entry_count;
      logic [DATA_W-1:0] element;
      logic              present;
   } set_result_type;

   // scoreboard: keeps a mirror of the store and the queue of predicted responses
   class set_store_scoreboard;
      logic [DATA_W-1:0] held [STORE_DEPTH];
      int                held_count;
      logic [CAP_W-1:0]  capacity;
      set_result_type    expected_q [$];
      int                mismatches;
      int                checked;

      function new();
         held_count = 0;
         capacity   = CAP_RESET;
         mismatches = 0;
         checked    = 0;
         foreach (held[i]) held[i] = '0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         capacity = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // work out the response of one accepted command and update the mirror
      function void note_request(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value,
                                 logic [IDX_W-1:0] slot);
         set_result_type r;
         bit             hit;
         int             pos;
         int             cap;
         r   = '0;
         hit = 0;
         pos = 0;
         cap = (capacity < STORE_DEPTH) ? capacity : STORE_DEPTH;
         if (cmd != CMD_GET) begin
            for (int i = 0; i < held_count; i++) begin
               if (!hit && held[i] == value) begin
                  hit = 1;
                  pos = i;
               end
            end
         end
         r.present = hit;
         unique case (cmd)
            CMD_ADD: begin
               // a full store refuses even a duplicate
               if (held_count >= cap) r.status = ST_FULL;
               else if (!hit) begin
                  held[held_count] = value;
                  held_count++;
               end
            end
            CMD_REMOVE: begin
               // close the gap, keeping the order of later entries
               if (hit) begin
                  for (int j = pos; j < held_count - 1; j++) held[j] = held[j + 1];
                  held_count--;
               end else begin
                  r.status = ST_ABSENT;
               end
            end
            CMD_FIND: ;
            default: begin
               if (slot < held_count) r.element = held[slot];
               else begin
                  r.element = BAD_VALUE;
                  r.status  = ST_BAD_INDEX;
               end
            end
         endcase
         r.entry_count = CAP_W'(held_count);
         expected_q.push_back(r);
      endfunction

      // compare one response transfer with the oldest prediction
      function void check_response(logic [RSP_TDATA_W-1:0] tdata);
         set_result_type got;
         set_result_type want;
         got = tdata;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response with nothing expected: %h", $realtime, tdata);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.present !== want.present || got.element !== want.element ||
             got.entry_count !== want.entry_count || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: mismatch on response %0d", $realtime, checked);
               $display("   expected present %b element %h count %0d status %0d",
                        want.present, want.element, want.entry_count, want.status);
               $display("   actual   present %b element %h count %0d status %0d",
                        got.present, got.element, got.entry_count, got.status);
            end
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]       req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en;
   logic [CAP_W-1:0]       csr_wr_data;

   set_store_scoreboard sb = new();

   bit                idle_on;
   int                hold_left;
   int                n_sent;
   int                n_cfg;
   logic [DATA_W-1:0] value_pool [POOL_SIZE];

   bounded_unique_set_store_unit #(.DEPTH(STORE_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // monitor: sample every transfer at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[DATA_W-1:0], req_tdata[DATA_W+IDX_W-1:DATA_W]);
         if (csr_wr_en) sb.set_capacity(csr_wr_data);
      end
   end

   // receiver: random stall bursts plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   // offer one command; called and returns at a falling edge
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                               input logic [IDX_W-1:0] slot);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, slot, value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_sent++;
      @(negedge clock);
   endtask

   // stop offering and wait until every response has arrived
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0 || rsp_tvalid);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      n_cfg++;
   endtask

   // mostly values from a small pool so that hits and duplicates are common
   function automatic logic [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return value_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   task automatic run_random_phase(input int n_items, input int add_pct);
      int               r;
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] slot;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'hFFFF_FFFF;
      value_pool[3] = 32'h0000_0000;
      for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;
      for (int k = 0; k < n_items; k++) begin
         r = $urandom_range(0, 99);
         if (r < add_pct) cmd = CMD_ADD;
         else if (r < add_pct + 25) cmd = CMD_REMOVE;
         else if (r < add_pct + 40) cmd = CMD_FIND;
         else cmd = CMD_GET;
         // gets mostly land near the filled range
         if (cmd == CMD_GET && $urandom_range(0, 4) != 0)
            slot = IDX_W'($urandom_range(0, sb.held_count + 1));
         else
            slot = IDX_W'($urandom_range(0, 31));
         send_request(cmd, pick_value(), slot);
      end
   endtask

   // main sequence
   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = CMD_ADD;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      idle_on     = 1'b1;
      hold_left   = 0;
      n_sent      = 0;
      n_cfg       = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty store, extremes, duplicates and a full store at reset capacity
      send_request(CMD_GET, 32'h0, 5'd0);
      send_request(CMD_REMOVE, 32'h0, 5'd31);
      send_request(CMD_FIND, 32'h8000_0000, 5'd0);
      send_request(CMD_ADD, 32'h8000_0000, 5'd31);
      send_request(CMD_ADD, 32'h7FFF_FFFF, 5'd0);
      send_request(CMD_ADD, 32'hFFFF_FFFF, 5'd0);
      send_request(CMD_ADD, 32'h0000_0000, 5'd0);
      send_request(CMD_ADD, 32'hFFFF_FFFF, 5'd0);
      send_request(CMD_ADD, 32'h0000_0005, 5'd0);
      send_request(CMD_ADD, 32'h0000_0006, 5'd0);
      send_request(CMD_ADD, 32'h0000_0000, 5'd0);
      send_request(CMD_GET, 32'hFFFF_FFFF, 5'd0);
      send_request(CMD_GET, 32'h0, 5'd4);
      send_request(CMD_GET, 32'h0, 5'd5);
      send_request(CMD_GET, 32'hFFFF_FFFF, 5'd31);
      send_request(CMD_FIND, 32'h7FFF_FFFF, 5'd31);
      // removes from the middle, the front and the back
      send_request(CMD_REMOVE, 32'h7FFF_FFFF, 5'd0);
      send_request(CMD_GET, 32'h0, 5'd1);
      send_request(CMD_REMOVE, 32'h8000_0000, 5'd0);
      send_request(CMD_REMOVE, 32'h0000_0005, 5'd0);
      send_request(CMD_GET, 32'h0, 5'd1);

      // capacity below the count, then a capacity of zero
      write_capacity(5'd1);
      send_request(CMD_ADD, 32'h1234_5678, 5'd0);
      send_request(CMD_REMOVE, 32'hFFFF_FFFF, 5'd0);
      send_request(CMD_ADD, 32'h1234_5678, 5'd0);
      write_capacity(5'd0);
      send_request(CMD_REMOVE, 32'h0000_0000, 5'd0);
      send_request(CMD_ADD, 32'h0000_0000, 5'd0);

      // random phases over several capacities; long receiver hold-off in the first
      write_capacity(5'd16);
      hold_left = 150;
      run_random_phase(120, 60);
      write_capacity(5'd8);
      run_random_phase(100, 35);
      write_capacity(5'd31);
      run_random_phase(100, 50);
      write_capacity(5'd0);
      idle_on = 1'b0;
      run_random_phase(40, 40);
      write_capacity(5'd1);
      idle_on = 1'b1;
      run_random_phase(60, 50);
      write_capacity(5'd12);
      run_random_phase(100, 30);
      write_capacity(5'd16);
      idle_on = 1'b0;
      run_random_phase(100, 45);

      wait_drained();
      repeat (4) @(negedge clock);
      $display("covered %0d commands under %0d capacity writes, extremes 0, 1, 16 and 31",
               n_sent, n_cfg);
      $display("%0d responses checked, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/buss_pkg.sv
rtl/buss_cell.sv
rtl/bounded_unique_set_store_unit.sv
rtl/buss_checker.sv
tb/sv/bounded_unique_set_store_unit_tb.sv
